>>> rtl/gwt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// G-code word tokeniser package
// Shared widths, codes and record types for the tokeniser datapath.
// ----------------------------------------------------------------------------
package gwt_pkg;

  localparam int FRAC_DIGITS = 3;
  localparam int MAX_DEPTH   = 255;
  localparam int VALUE_WIDTH = 32;

  localparam int SCALE       = 10 ** FRAC_DIGITS;
  localparam int FRAC_WIDTH  = $clog2(SCALE);
  localparam int FCNT_WIDTH  = $clog2(FRAC_DIGITS + 1);
  localparam int DEPTH_WIDTH = $clog2(MAX_DEPTH + 1);

  // Integer part clamps where both the value and the code are already saturated
  localparam longint VAL_ACC_LIM = ((longint'(1) << (VALUE_WIDTH - 1)) / SCALE) + 1;
  localparam longint ACC_MAX     = (VAL_ACC_LIM > 32769) ? VAL_ACC_LIM : 32769;
  localparam int ACC_WIDTH       = $clog2(ACC_MAX + 1);
  localparam int MAG_WIDTH       = $clog2((ACC_MAX + 1) * SCALE);
  localparam int CMP_WIDTH       = (MAG_WIDTH > VALUE_WIDTH) ? MAG_WIDTH : VALUE_WIDTH;

  localparam int TDATA_WIDTH = 56;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_LEAD = 5'b00010,
    PH_INT  = 5'b00100,
    PH_FRAC = 5'b01000,
    PH_REST = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    KIND_AXIS = 3'd0,
    KIND_G    = 3'd1,
    KIND_M    = 3'd2,
    KIND_OK   = 3'd3,
    KIND_FAIL = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CLS_AXIS = 2'd0,
    CLS_G    = 2'd1,
    CLS_M    = 2'd2
  } cls_t;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CHAR    = 2'd1;
  localparam logic [1:0] ERR_TWO_CMD = 2'd2;

  typedef struct packed {
    logic [DEPTH_WIDTH-1:0] depth;
    logic                   word_seen;
    logic                   cmd_seen;
    phase_t                 phase;
    logic [4:0]             letter;
    cls_t                   cls;
    logic                   neg;
    logic [ACC_WIDTH-1:0]   acc;
    logic [FRAC_WIDTH-1:0]  frac;
    logic [FCNT_WIDTH-1:0]  fcnt;
    logic                   digit_seen;
    logic                   odd_seen;
    logic [1:0]             err;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '{
    depth: '0, word_seen: 1'b0, cmd_seen: 1'b0, phase: PH_IDLE, letter: 5'd0,
    cls: CLS_AXIS, neg: 1'b0, acc: '0, frac: '0, fcnt: '0, digit_seen: 1'b0,
    odd_seen: 1'b0, err: ERR_NONE
  };

  typedef struct packed {
    kind_t              kind;
    logic [4:0]         letter;
    logic signed [31:0] value;
    logic signed [15:0] code;
    logic [1:0]         err;
    logic               last;
  } result_t;

  localparam result_t RESULT_ZERO = '{
    kind: KIND_AXIS, letter: 5'd0, value: 32'sd0, code: 16'sd0, err: ERR_NONE,
    last: 1'b0
  };

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

endpackage
`default_nettype wire

>>> rtl/gcode_word_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// G-code word tokeniser
// Splits a byte stream of G-code lines into axis words, commands and status.
// ----------------------------------------------------------------------------
// Input: one character per s_tvalid/s_tready transfer; a zero byte ends a line.
// Output: m_tuser carries the item kind, m_tdata the letter, value (thousandths),
// code and error; m_tlast marks the last result caused by one character.
// A character yields zero, one or two results; the final one on every line is
// its status (ok or failed), given on the zero byte.
// The first result of a character is offered on m_tvalid after it has passed
// the input register and then the output register.
// Throughput: one character per cycle while the receiver takes results. A character
// that yields two results fills both entries of the output register, so a following
// character that also yields two results waits; all others pass on.
// Receiver stall: the output register holds up to two results; input stays
// open while the pending character's results fit, otherwise s_tready falls.
// Reset clears the line state, the input register and the output register;
// the block is ready for a new line as soon as reset is released.
// ----------------------------------------------------------------------------
module gcode_word_tokenizer
  import gwt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,  // [7:0] char_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_WIDTH-1:0] m_tdata,  // [4:0] letter, [36:5] value, [52:37] code,
                                           // [54:53] error_code, [55] zero
  output logic [2:0]             m_tuser,  // [2:0] item_kind
  output logic                   m_tlast   // last_of_run
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        consume;
  logic [1:0]  room;
  line_state_t state;
  line_state_t state_next;
  step_out_t   step_res;
  result_t     head;

  gwt_step u_step (
    .cur       (state),
    .char_byte (in_byte),
    .nxt       (state_next),
    .res       (step_res)
  );

  assign consume  = in_valid && (step_res.count <= room);
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      state    <= LINE_CLEAR;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (consume) begin
        in_valid <= 1'b0;
      end
      if (consume) begin
        state <= state_next;
      end
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  gwt_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (consume),
    .wr    (step_res),
    .room  (room),
    .valid (m_tvalid),
    .head  (head),
    .ready (m_tready)
  );

  assign m_tdata = {1'b0, head.err, head.code, head.value, head.letter};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

`ifndef NO_ASSERTIONS
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tuser == KIND_OK) || (m_tuser == KIND_FAIL))) |-> m_tlast)
    else $error("status result not marked last");
  a_line_clear: assert property (@(posedge clk) disable iff (rst)
    (consume && (in_byte == 8'h00)) |=> ((state.phase == PH_IDLE) && (state.depth == '0)))
    else $error("line state not cleared at end of line");
`endif

endmodule
`default_nettype wire

>>> rtl/gwt_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// G-code word tokeniser step logic
// Next line state and up to two results for one character.
// ----------------------------------------------------------------------------
module gwt_step
  import gwt_pkg::*;
(
  input  line_state_t cur,
  input  logic [7:0]  char_byte,
  output line_state_t nxt,
  output step_out_t   res
);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  localparam logic [4:0]            N_LETTER  = 5'(CH_N - CH_UA);
  localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = DEPTH_WIDTH'(MAX_DEPTH);
  localparam logic [ACC_WIDTH-1:0]  ACC_SAT   = ACC_WIDTH'(ACC_MAX);
  localparam logic [FRAC_WIDTH-1:0] FRAC_HALF = FRAC_WIDTH'(5 * (SCALE / 10));
  localparam logic [FCNT_WIDTH-1:0] FCNT_FULL = FCNT_WIDTH'(FRAC_DIGITS);
  localparam logic [CMP_WIDTH-1:0]  VAL_LIM   = CMP_WIDTH'(1) << (VALUE_WIDTH - 1);
  localparam logic [ACC_WIDTH:0]    CODE_NEG_LIM = (ACC_WIDTH + 1)'(32768);
  localparam logic [ACC_WIDTH:0]    CODE_POS_LIM = (ACC_WIDTH + 1)'(32767);

  function automatic int pow10(input int e);
    int p;
    p = 1;
    for (int i = 0; i < e; i++) p = p * 10;
    return p;
  endfunction

  function automatic logic [FRAC_WIDTH-1:0] frac_weight(input logic [FCNT_WIDTH-1:0] n);
    logic [FRAC_WIDTH-1:0] w;
    w = '0;
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      if (n == FCNT_WIDTH'(i)) w = FRAC_WIDTH'(pow10(FRAC_DIGITS - 1 - i));
    end
    return w;
  endfunction

  function automatic line_state_t clear_number(input line_state_t s);
    line_state_t r;
    r            = s;
    r.neg        = 1'b0;
    r.acc        = '0;
    r.frac       = '0;
    r.fcnt       = '0;
    r.digit_seen = 1'b0;
    r.odd_seen   = 1'b0;
    return r;
  endfunction

  logic                    is_digit;
  logic                    is_ws;
  logic                    is_odd_ws;
  logic                    is_upper;
  logic                    is_lower;
  logic                    is_sign;
  logic [3:0]              dig;
  logic [7:0]              up_char;
  logic [ACC_WIDTH+3:0]    acc_mul;
  logic [ACC_WIDTH-1:0]    acc_next;
  logic [FRAC_WIDTH-1:0]   frac_add;
  logic [MAG_WIDTH-1:0]    mag;
  logic [CMP_WIDTH-1:0]    mag_c;
  logic [CMP_WIDTH-1:0]    val_sat;
  logic [ACC_WIDTH:0]      cm;
  logic [15:0]             cm_sat;
  logic signed [31:0]      word_value;
  logic signed [15:0]      word_code;
  line_state_t             st;
  logic                    num_v;
  logic                    end_v;
  logic                    go_top;
  logic                    go_rest;
  result_t                 num_r;
  result_t                 end_r;

  assign is_digit  = (char_byte >= CH_0) && (char_byte <= CH_9);
  assign is_ws     = (char_byte == CH_SPACE) || (char_byte == CH_TAB) ||
                     (char_byte == CH_LF) || (char_byte == CH_CR);
  assign is_odd_ws = (char_byte == CH_VT) || (char_byte == CH_FF);
  assign is_upper  = (char_byte >= CH_UA) && (char_byte <= CH_UZ);
  assign is_lower  = (char_byte >= CH_LA) && (char_byte <= CH_LZ);
  assign is_sign   = (char_byte == CH_PLUS) || (char_byte == CH_MINUS);
  assign dig       = 4'(char_byte - CH_0);
  assign up_char   = is_lower ? (char_byte - CASE_GAP) : char_byte;

  // acc * 10 + digit, clamped
  assign acc_mul  = ((ACC_WIDTH + 4)'(cur.acc) << 3) + ((ACC_WIDTH + 4)'(cur.acc) << 1) +
                    (ACC_WIDTH + 4)'(dig);
  assign acc_next = (acc_mul > (ACC_WIDTH + 4)'(ACC_SAT)) ? ACC_SAT : acc_mul[ACC_WIDTH-1:0];
  assign frac_add = FRAC_WIDTH'(FRAC_WIDTH'(dig) * frac_weight(cur.fcnt));

  // Word value in fixed point, saturated
  assign mag     = MAG_WIDTH'(cur.acc) * MAG_WIDTH'(SCALE) + MAG_WIDTH'(cur.frac);
  assign mag_c   = CMP_WIDTH'(mag);
  assign val_sat = cur.neg ? ((mag_c > VAL_LIM) ? VAL_LIM : mag_c)
                           : ((mag_c > (VAL_LIM - 1'b1)) ? (VAL_LIM - 1'b1) : mag_c);
  assign word_value = 32'(cur.neg ? (CMP_WIDTH'(0) - val_sat) : val_sat);

  // Command code, rounded half away from zero
  assign cm        = (ACC_WIDTH + 1)'(cur.acc) + (ACC_WIDTH + 1)'(cur.frac >= FRAC_HALF);
  assign cm_sat    = cur.neg ? ((cm > CODE_NEG_LIM) ? CODE_NEG_LIM[15:0] : cm[15:0])
                             : ((cm > CODE_POS_LIM) ? CODE_POS_LIM[15:0] : cm[15:0]);
  assign word_code = cur.neg ? -$signed(cm_sat) : $signed(cm_sat);

  always_comb begin
    st      = cur;
    num_v   = 1'b0;
    end_v   = 1'b0;
    go_top  = 1'b0;
    go_rest = 1'b0;
    num_r   = RESULT_ZERO;
    end_r   = RESULT_ZERO;

    unique case (cur.phase)
      PH_IDLE: go_top = 1'b1;
      PH_REST: go_rest = 1'b1;
      default: begin
        if ((cur.phase == PH_LEAD) && (is_ws || is_odd_ws)) begin
          if (is_odd_ws) st.odd_seen = 1'b1;
        end else if ((cur.phase == PH_LEAD) && is_sign) begin
          st.neg   = (char_byte == CH_MINUS);
          st.phase = PH_INT;
        end else if (is_digit) begin
          if (cur.phase == PH_FRAC) begin
            if (cur.fcnt < FCNT_FULL) begin
              st.frac = cur.frac + frac_add;
              st.fcnt = cur.fcnt + 1'b1;
            end
          end else begin
            st.acc   = acc_next;
            st.phase = PH_INT;
          end
          st.digit_seen = 1'b1;
        end else if ((char_byte == CH_DOT) && (cur.phase != PH_FRAC)) begin
          st.phase = PH_FRAC;
        end else if (cur.digit_seen) begin
          st.phase = PH_IDLE;
          if (cur.cls != CLS_AXIS) begin
            if (cur.cmd_seen) begin
              st.err   = ERR_TWO_CMD;
              st.phase = PH_REST;
            end else begin
              st.cmd_seen  = 1'b1;
              st.word_seen = 1'b1;
              num_v        = 1'b1;
              num_r.kind   = (cur.cls == CLS_G) ? KIND_G : KIND_M;
              num_r.letter = cur.letter;
              num_r.code   = word_code;
            end
          end else if ((cur.letter == N_LETTER) && !cur.word_seen) begin
            st.word_seen = 1'b1;
          end else begin
            st.word_seen = 1'b1;
            num_v        = 1'b1;
            num_r.letter = cur.letter;
            num_r.value  = word_value;
          end
          st = clear_number(st);
          if (st.phase == PH_REST) go_rest = 1'b1;
          else go_top = 1'b1;
        end else begin
          // bare letter reads zero
          num_v        = 1'b1;
          num_r.letter = cur.letter;
          st           = clear_number(st);
          if ((cur.phase != PH_LEAD) || cur.odd_seen) begin
            st.err   = ERR_CHAR;
            st.phase = PH_REST;
            go_rest  = 1'b1;
          end else begin
            st.phase = PH_IDLE;
            go_top   = 1'b1;
          end
        end
      end
    endcase

    if ((go_top || go_rest) && (char_byte == CH_NUL)) begin
      end_v      = 1'b1;
      end_r.kind = (st.err != ERR_NONE) ? KIND_FAIL : KIND_OK;
      end_r.err  = st.err;
      st         = LINE_CLEAR;
    end else if (go_top) begin
      priority if ((char_byte == CH_SEMI) || ((char_byte == CH_STAR) && (st.depth == '0))) begin
        st.phase = PH_REST;
      end else if (char_byte == CH_LPAREN) begin
        if (st.depth < DEPTH_MAX) st.depth = st.depth + 1'b1;
      end else if (char_byte == CH_RPAREN) begin
        if (st.depth != '0) st.depth = st.depth - 1'b1;
      end else if ((st.depth != '0) || is_ws) begin
        st.phase = st.phase;
      end else if (is_upper || is_lower) begin
        st        = clear_number(st);
        st.letter = 5'(up_char - CH_UA);
        st.cls    = (up_char == CH_G) ? CLS_G : ((up_char == CH_M) ? CLS_M : CLS_AXIS);
        st.phase  = PH_LEAD;
      end else begin
        st.err   = ERR_CHAR;
        st.phase = PH_REST;
      end
    end

    nxt              = st;
    res.count        = 2'(num_v) + 2'(end_v);
    res.first        = num_v ? num_r : end_r;
    res.first.last   = !(num_v && end_v);
    res.second       = end_r;
    res.second.last  = 1'b1;
  end

endmodule
`default_nettype wire

>>> rtl/gwt_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// G-code word tokeniser result queue
// Two-entry output register; takes up to two results, hands out one a cycle while ready is high.
// ----------------------------------------------------------------------------
module gwt_outq
  import gwt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  step_out_t wr,
  output logic [1:0] room,
  output logic      valid,
  output result_t   head,
  input  logic      ready
);

  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic [1:0] kept;
  logic       pop;
  result_t    slot0;
  result_t    slot1;
  result_t    slot0_next;
  result_t    slot1_next;

  assign valid = (cnt != 2'd0);
  assign head  = slot0;
  assign pop   = valid && ready;
  assign kept  = cnt - 2'(pop);
  assign room  = 2'd2 - kept;

  always_comb begin
    slot0_next = pop ? slot1 : slot0;
    slot1_next = slot1;
    cnt_next   = kept;
    if (push && (wr.count != 2'd0)) begin
      cnt_next = kept + wr.count;
      if (kept == 2'd0) begin
        slot0_next = wr.first;
        slot1_next = wr.second;
      end else begin
        slot1_next = wr.first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("result queue overfilled");
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    ((cnt == 2'd2) && !slot0.last) |-> slot1.last)
    else $error("first result of a pair not followed by its final one");
`endif

endmodule
`default_nettype wire
